@@ rtl/gild_pkg.sv @@
// ----------------------------------------------------------------------------
// Instruction length decode package
// Shared types and encoding constants for the instruction length decoder.
// ----------------------------------------------------------------------------
package gild_pkg;

  // Architecture generation codes held in the configuration register.
  localparam logic [1:0] GEN_FIRST  = 2'd0;
  localparam logic [1:0] GEN_SECOND = 2'd1;
  localparam logic [1:0] GEN_THIRD  = 2'd2;

  // Result lengths in bytes.
  localparam logic [3:0] LEN_NONE  = 4'd0;
  localparam logic [3:0] LEN_SHORT = 4'd4;
  localparam logic [3:0] LEN_LONG  = 4'd8;

  // Scalar encoding selectors in bits 27..23 when bits 29..28 are both set.
  localparam logic [4:0] ENC_SOP1 = 5'h1d;
  localparam logic [4:0] ENC_SOPC = 5'h1e;
  localparam logic [4:0] ENC_SOPP = 5'h1f;

  // Immediate scalar opcode that carries a literal, per generation.
  localparam logic [4:0] SOPK_LIT_OP_EARLY = 5'd21;
  localparam logic [4:0] SOPK_LIT_OP_LATE  = 5'd20;

  // Memory and export classes that take a second dword, one bit per class.
  localparam logic [15:0] MEM8_MASK_EARLY = 16'h55d0;
  localparam logic [15:0] MEM8_MASK_LATE  = 16'h15d3;
  localparam logic [3:0]  MEM_CLASS_GEN2_ONLY = 4'd7;

  // Vector encoding selectors in bits 30..25.
  localparam logic [5:0] VEC_TOP_VOPC = 6'h3e;
  localparam logic [5:0] VEC_TOP_VOP1 = 6'h3f;

  // Multiply-add-constant binary vector opcodes.
  localparam logic [5:0] MAD_OP_EARLY_A = 6'd32;
  localparam logic [5:0] MAD_OP_EARLY_B = 6'd33;
  localparam logic [5:0] MAD_OP_LATE_A  = 6'd23;
  localparam logic [5:0] MAD_OP_LATE_B  = 6'd24;
  localparam logic [5:0] MAD_OP_LATE_C  = 6'd36;
  localparam logic [5:0] MAD_OP_LATE_D  = 6'd37;

  // Source operand codes.
  localparam logic [7:0] SRC_LITERAL_BYTE = 8'hff;
  localparam logic [8:0] SRC_LITERAL      = 9'h0ff;
  localparam logic [8:0] SRC_SDWA         = 9'h0f9;
  localparam logic [8:0] SRC_DPP          = 9'h0fa;

  typedef enum logic [1:0] {
    KIND_SCALAR,
    KIND_MEM,
    KIND_VEC
  } kind_e;

  // Per-family verdicts produced by the classify stage.
  typedef struct packed {
    kind_e kind;
    logic  scalar_long;
    logic  mem_long;
    logic  vec_long;
  } flags_t;

endpackage

@@ rtl/gild_if.sv @@
// ----------------------------------------------------------------------------
// Instruction length decode channels
// Valid/ready channels carrying instruction words in and lengths out.
// ----------------------------------------------------------------------------
interface gild_in_if;
  logic        valid;
  logic        ready;
  logic        have_full_word;
  logic [31:0] instr_word;

  modport source (output valid, output have_full_word, output instr_word, input ready);
  modport sink   (input valid, input have_full_word, input instr_word, output ready);
endinterface

interface gild_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] length_bytes;

  modport source (output valid, output length_bytes, input ready);
  modport sink   (input valid, input length_bytes, output ready);
endinterface

@@ rtl/gild_classify.sv @@
// ----------------------------------------------------------------------------
// Instruction length decode classifier
// Works out, for one instruction word, which encoding family it belongs to
// and whether each family's rule calls for a trailing literal dword.
// ----------------------------------------------------------------------------
module gild_classify (
  input  logic [31:0]           word_i,
  input  logic [1:0]            gen_i,
  output gild_pkg::flags_t      flags_o
);

  logic       late;
  logic       byte0_lit;
  logic       byte1_lit;
  logic [8:0] src;
  logic       src_long;
  logic [4:0] enc;
  logic [3:0] cls;
  logic [5:0] top;
  logic       mad;
  logic       scalar_long;
  logic       mem_long;

  assign late      = (gen_i >= gild_pkg::GEN_THIRD);
  assign byte0_lit = (word_i[7:0] == gild_pkg::SRC_LITERAL_BYTE);
  assign byte1_lit = (word_i[15:8] == gild_pkg::SRC_LITERAL_BYTE);
  assign src       = word_i[8:0];
  assign src_long  = (src == gild_pkg::SRC_LITERAL) ||
                     (late && ((src == gild_pkg::SRC_SDWA) || (src == gild_pkg::SRC_DPP)));
  assign enc       = word_i[27:23];
  assign cls       = word_i[29:26];
  assign top       = word_i[30:25];

  always_comb begin
    if (word_i[29:28] == 2'b11) begin
      case (enc)
        gild_pkg::ENC_SOP1: scalar_long = byte0_lit;
        gild_pkg::ENC_SOPC: scalar_long = byte0_lit || byte1_lit;
        gild_pkg::ENC_SOPP: scalar_long = 1'b0;
        default: begin
          // Everything else is the immediate form; one opcode carries a literal.
          scalar_long = late ? (enc == gild_pkg::SOPK_LIT_OP_LATE)
                             : (enc == gild_pkg::SOPK_LIT_OP_EARLY);
        end
      endcase
    end else begin
      scalar_long = byte0_lit || byte1_lit;
    end
  end

  always_comb begin
    if (late) begin
      mem_long = gild_pkg::MEM8_MASK_LATE[cls];
    end else begin
      // The early table lists one class that is only long on the second generation.
      mem_long = gild_pkg::MEM8_MASK_EARLY[cls] &&
                 ((cls != gild_pkg::MEM_CLASS_GEN2_ONLY) || (gen_i == gild_pkg::GEN_SECOND));
    end
  end

  always_comb begin
    if (late) begin
      mad = (top == gild_pkg::MAD_OP_LATE_A) || (top == gild_pkg::MAD_OP_LATE_B) ||
            (top == gild_pkg::MAD_OP_LATE_C) || (top == gild_pkg::MAD_OP_LATE_D);
    end else begin
      mad = (top == gild_pkg::MAD_OP_EARLY_A) || (top == gild_pkg::MAD_OP_EARLY_B);
    end
  end

  always_comb begin
    flags_o.scalar_long = scalar_long;
    flags_o.mem_long    = mem_long;
    if ((top == gild_pkg::VEC_TOP_VOPC) || (top == gild_pkg::VEC_TOP_VOP1)) begin
      flags_o.vec_long = src_long;
    end else begin
      flags_o.vec_long = mad || src_long;
    end
    if (!word_i[31]) begin
      flags_o.kind = gild_pkg::KIND_VEC;
    end else if (!word_i[30]) begin
      flags_o.kind = gild_pkg::KIND_SCALAR;
    end else begin
      flags_o.kind = gild_pkg::KIND_MEM;
    end
  end

endmodule

@@ rtl/gpu_instruction_length_decode.sv @@
// Path: a word accepted at the input is registered in stage 1, then in
// stage 2, and shows its length from the stage 3 register on the output.
// Throughput: one word per cycle through three register stages when not stalled.
// Reset: the stage valid bits clear and the generation register returns to
// the first generation; payload registers are not reset.
// ----------------------------------------------------------------------------
// GPU instruction length decode
// Reports 0, 4 or 8 bytes for the first dword of an instruction, following
// the encoding rules of the configured architecture generation.
// ----------------------------------------------------------------------------
module gpu_instruction_length_decode (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_wdata_i,
  gild_in_if.sink    in_i,
  gild_out_if.source out_o
);

  logic [1:0] gen_q;

  logic        s1_valid_q;
  logic        s1_full_q;
  logic [31:0] s1_word_q;
  logic [1:0]  s1_gen_q;

  logic             s2_valid_q;
  logic             s2_full_q;
  gild_pkg::flags_t s2_flags_d;
  gild_pkg::flags_t s2_flags_q;

  logic       s3_valid_q;
  logic [3:0] s3_len_d;
  logic [3:0] s3_len_q;

  logic adv1;
  logic adv2;
  logic adv3;
  logic sel_long;

  // Each stage moves on when the stage after it is empty or moving too.
  assign adv3     = !s3_valid_q || out_o.ready;
  assign adv2     = !s2_valid_q || adv3;
  assign adv1     = !s1_valid_q || adv2;
  assign in_i.ready = adv1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_q <= gild_pkg::GEN_FIRST;
    end else if (cfg_we_i) begin
      gen_q <= cfg_wdata_i;
    end
  end

  // Stage 1: capture the word together with the generation it is decoded under.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (adv1) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1 && in_i.valid) begin
      s1_full_q <= in_i.have_full_word;
      s1_word_q <= in_i.instr_word;
      s1_gen_q  <= gen_q;
    end
  end

  // Stage 2: per-family rules.
  gild_classify u_classify (
    .word_i  (s1_word_q),
    .gen_i   (s1_gen_q),
    .flags_o (s2_flags_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (adv2) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv2 && s1_valid_q) begin
      s2_full_q  <= s1_full_q;
      s2_flags_q <= s2_flags_d;
    end
  end

  // Stage 3: pick the verdict of the word's family and form the length.
  always_comb begin
    case (s2_flags_q.kind)
      gild_pkg::KIND_SCALAR: sel_long = s2_flags_q.scalar_long;
      gild_pkg::KIND_MEM:    sel_long = s2_flags_q.mem_long;
      gild_pkg::KIND_VEC:    sel_long = s2_flags_q.vec_long;
      default:               sel_long = 1'b0;
    endcase
    if (!s2_full_q) begin
      s3_len_d = gild_pkg::LEN_NONE;
    end else if (sel_long) begin
      s3_len_d = gild_pkg::LEN_LONG;
    end else begin
      s3_len_d = gild_pkg::LEN_SHORT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else if (adv3) begin
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv3 && s2_valid_q) begin
      s3_len_q <= s3_len_d;
    end
  end

  assign out_o.valid        = s3_valid_q;
  assign out_o.length_bytes = s3_len_q;

endmodule

@@ rtl/gild_checker.sv @@
// ----------------------------------------------------------------------------
// Instruction length decode checker
// Port-level assertions on the decoder, attached to the top level by bind.
// ----------------------------------------------------------------------------
module gild_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        in_full_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [3:0]  out_len_i
);

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_i;

  // Only three lengths exist.
  a_len_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_len_i == gild_pkg::LEN_NONE) ||
                    (out_len_i == gild_pkg::LEN_SHORT) ||
                    (out_len_i == gild_pkg::LEN_LONG))
    else $error("length outside 0, 4 and 8");

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_len_i))
    else $error("result word changed while stalled");

  // A word without a full dword comes out as zero bytes if the output is not stalled.
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !in_full_i ##1 out_ready_i ##1 out_ready_i
      |=> out_valid_i && (out_len_i == gild_pkg::LEN_NONE))
    else $error("partial word did not give zero length");

  // A full dword always comes out as four or eight bytes.
  a_full_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_full_i ##1 out_ready_i ##1 out_ready_i
      |=> out_valid_i && ((out_len_i == gild_pkg::LEN_SHORT) ||
                          (out_len_i == gild_pkg::LEN_LONG)))
    else $error("full word did not give four or eight bytes");

endmodule

bind gpu_instruction_length_decode gild_checker u_gild_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_full_i   (in_i.have_full_word),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_len_i   (out_o.length_bytes)
);

@@ sim/tb.sv @@
// ----------------------------------------------------------------------------
// Instruction length decode testbench
// Drives instruction words into the length decoder under random source gaps
// and sink stalls, across every generation code, and checks each returned
// length against a typed length or a predictor from the encoding rules.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // The register is two bits wide; code 3 decodes like the third generation.
  localparam logic [1:0] GEN_CODE3   = 2'd3;
  localparam int         HOLD_CYCLES = 200;
  localparam int         STALL_LIMIT = 1000;
  localparam int         PHASE_WORDS = 160;
  localparam int         NUM_PHASES  = 8;

  typedef struct packed {
    logic [1:0]  gen;
    logic        full;
    logic [31:0] word;
    logic        fixed;
    logic [3:0]  len;
  } dir_row_t;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [1:0] cfg_wdata_i;

  gild_in_if  in_ch ();
  gild_out_if out_ch ();

  gpu_instruction_length_decode dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_ch),
    .out_o       (out_ch)
  );

  always #10 clk_i = ~clk_i;

  logic [3:0] len_q[$];
  logic [1:0] gen_shadow;
  int         mismatches  = 0;
  int         stall_count = 0;
  logic       src_idle_on = 1'b1;
  logic       snk_idle_on = 1'b1;
  logic       hold_req    = 1'b0;
  logic       run_done    = 1'b0;

  // Rows with a typed length are the ones that need no working out.
  dir_row_t dir_rows [26] = '{
    '{gild_pkg::GEN_FIRST,  1'b0, 32'hffffffff, 1'b1, gild_pkg::LEN_NONE},
    '{gild_pkg::GEN_FIRST,  1'b1, 32'h00000000, 1'b0, gild_pkg::LEN_NONE},
    '{gild_pkg::GEN_FIRST,  1'b1, 32'hffffffff, 1'b0, gild_pkg::LEN_NONE},
    '{gild_pkg::GEN_FIRST,  1'b1, 32'h800000ff, 1'b1, gild_pkg::LEN_LONG},
    '{gild_pkg::GEN_FIRST,  1'b1, 32'h8000ff00, 1'b1, gild_pkg::LEN_LONG},
    '{gild_pkg::GEN_FIRST,  1'b1, 32'hbe8000ff, 1'b1, gild_pkg::LEN_LONG},
    '{gild_pkg::GEN_FIRST,  1'b1, 32'hbf00ff00, 1'b1, gild_pkg::LEN_LONG},
    '{gild_pkg::GEN_FIRST,  1'b1, 32'hbf80ffff, 1'b1, gild_pkg::LEN_SHORT},
    '{gild_pkg::GEN_FIRST,  1'b1, 32'hba800000, 1'b1, gild_pkg::LEN_LONG},
    '{gild_pkg::GEN_FIRST,  1'b1, 32'hba000000, 1'b0, gild_pkg::LEN_NONE},
    '{gild_pkg::GEN_FIRST,  1'b1, 32'hdc000000, 1'b0, gild_pkg::LEN_NONE},
    '{gild_pkg::GEN_FIRST,  1'b1, 32'h40000000, 1'b0, gild_pkg::LEN_NONE},
    '{gild_pkg::GEN_FIRST,  1'b1, 32'h7e0001ff, 1'b0, gild_pkg::LEN_NONE},
    '{gild_pkg::GEN_FIRST,  1'b1, 32'h7c0000ff, 1'b1, gild_pkg::LEN_LONG},
    '{gild_pkg::GEN_FIRST,  1'b1, 32'h7e0000f9, 1'b0, gild_pkg::LEN_NONE},
    '{gild_pkg::GEN_SECOND, 1'b1, 32'hdc000000, 1'b0, gild_pkg::LEN_NONE},
    '{gild_pkg::GEN_SECOND, 1'b1, 32'hd0000000, 1'b0, gild_pkg::LEN_NONE},
    '{gild_pkg::GEN_THIRD,  1'b1, 32'hba000000, 1'b0, gild_pkg::LEN_NONE},
    '{gild_pkg::GEN_THIRD,  1'b1, 32'hba800000, 1'b0, gild_pkg::LEN_NONE},
    '{gild_pkg::GEN_THIRD,  1'b1, 32'hc0000000, 1'b0, gild_pkg::LEN_NONE},
    '{gild_pkg::GEN_THIRD,  1'b1, 32'h2e000000, 1'b0, gild_pkg::LEN_NONE},
    '{gild_pkg::GEN_THIRD,  1'b1, 32'h7e0000fa, 1'b0, gild_pkg::LEN_NONE},
    '{gild_pkg::GEN_THIRD,  1'b1, 32'h7c0000f9, 1'b0, gild_pkg::LEN_NONE},
    '{GEN_CODE3,            1'b1, 32'h48000000, 1'b0, gild_pkg::LEN_NONE},
    '{GEN_CODE3,            1'b1, 32'h40000000, 1'b0, gild_pkg::LEN_NONE},
    '{GEN_CODE3,            1'b0, 32'h800000ff, 1'b1, gild_pkg::LEN_NONE}
  };

  function automatic logic src_needs_literal(logic [8:0] src, logic late);
    return (src == gild_pkg::SRC_LITERAL) ||
           (late && (src == gild_pkg::SRC_SDWA || src == gild_pkg::SRC_DPP));
  endfunction

  function automatic logic [3:0] predict_length(logic [1:0] gen, logic full,
                                                logic [31:0] w);
    logic       late;
    logic       long_word;
    logic       byte_lit;
    logic [3:0] cls;
    logic [5:0] vop;
    late     = (gen >= gild_pkg::GEN_THIRD);
    byte_lit = (w[7:0] == gild_pkg::SRC_LITERAL_BYTE) ||
               (w[15:8] == gild_pkg::SRC_LITERAL_BYTE);
    cls      = w[29:26];
    vop      = w[30:25];
    if (!full) begin
      return gild_pkg::LEN_NONE;
    end
    if (w[31] && !w[30]) begin
      if (w[29:28] == 2'b11) begin
        case (w[27:23])
          gild_pkg::ENC_SOP1: long_word = (w[7:0] == gild_pkg::SRC_LITERAL_BYTE);
          gild_pkg::ENC_SOPC: long_word = byte_lit;
          gild_pkg::ENC_SOPP: long_word = 1'b0;
          default:  long_word = late ? (w[27:23] == gild_pkg::SOPK_LIT_OP_LATE)
                                     : (w[27:23] == gild_pkg::SOPK_LIT_OP_EARLY);
        endcase
      end else begin
        long_word = byte_lit;
      end
    end else if (w[31]) begin
      if (late) begin
        long_word = gild_pkg::MEM8_MASK_LATE[cls];
      end else begin
        long_word = gild_pkg::MEM8_MASK_EARLY[cls] &&
                    (cls != gild_pkg::MEM_CLASS_GEN2_ONLY ||
                     gen == gild_pkg::GEN_SECOND);
      end
    end else if (vop == gild_pkg::VEC_TOP_VOPC || vop == gild_pkg::VEC_TOP_VOP1) begin
      long_word = src_needs_literal(w[8:0], late);
    end else begin
      if (late) begin
        long_word = (vop == gild_pkg::MAD_OP_LATE_A) ||
                    (vop == gild_pkg::MAD_OP_LATE_B) ||
                    (vop == gild_pkg::MAD_OP_LATE_C) ||
                    (vop == gild_pkg::MAD_OP_LATE_D);
      end else begin
        long_word = (vop == gild_pkg::MAD_OP_EARLY_A) ||
                    (vop == gild_pkg::MAD_OP_EARLY_B);
      end
      long_word = long_word || src_needs_literal(w[8:0], late);
    end
    return long_word ? gild_pkg::LEN_LONG : gild_pkg::LEN_SHORT;
  endfunction

  // Mostly well-formed words with the fields that matter steered towards
  // their special values; the rest is raw noise.
  function automatic logic [31:0] random_instr_word();
    logic [31:0] w;
    logic [8:0]  src;
    w = $urandom();
    case ($urandom_range(0, 4))
      0:       src = gild_pkg::SRC_LITERAL;
      1:       src = gild_pkg::SRC_SDWA;
      2:       src = gild_pkg::SRC_DPP;
      3:       src = {1'b1, gild_pkg::SRC_LITERAL_BYTE};
      default: src = 9'($urandom());
    endcase
    case ($urandom_range(0, 9))
      2: begin
        w[31:30] = 2'b10;
        w[29:28] = 2'($urandom_range(0, 2));
        if ($urandom_range(0, 1)) w[7:0] = gild_pkg::SRC_LITERAL_BYTE;
        if ($urandom_range(0, 1)) w[15:8] = gild_pkg::SRC_LITERAL_BYTE;
      end
      3, 4: begin
        w[31:28] = 4'b1011;
        case ($urandom_range(0, 5))
          0: w[27:23] = gild_pkg::ENC_SOP1;
          1: w[27:23] = gild_pkg::ENC_SOPC;
          2: w[27:23] = gild_pkg::ENC_SOPP;
          3: w[27:23] = gild_pkg::SOPK_LIT_OP_EARLY;
          4: w[27:23] = gild_pkg::SOPK_LIT_OP_LATE;
          default: ;
        endcase
        if ($urandom_range(0, 1)) w[7:0] = gild_pkg::SRC_LITERAL_BYTE;
        if ($urandom_range(0, 1)) w[15:8] = gild_pkg::SRC_LITERAL_BYTE;
      end
      5: w[31:30] = 2'b11;
      6, 7: begin
        w[31] = 1'b0;
        case ($urandom_range(0, 2))
          0: w[30:25] = gild_pkg::VEC_TOP_VOPC;
          1: w[30:25] = gild_pkg::VEC_TOP_VOP1;
          default: ;
        endcase
        w[8:0] = src;
      end
      8, 9: begin
        w[31] = 1'b0;
        case ($urandom_range(0, 6))
          0: w[30:25] = gild_pkg::MAD_OP_EARLY_A;
          1: w[30:25] = gild_pkg::MAD_OP_EARLY_B;
          2: w[30:25] = gild_pkg::MAD_OP_LATE_A;
          3: w[30:25] = gild_pkg::MAD_OP_LATE_B;
          4: w[30:25] = gild_pkg::MAD_OP_LATE_C;
          5: w[30:25] = gild_pkg::MAD_OP_LATE_D;
          default: ;
        endcase
        w[8:0] = src;
      end
      default: ;
    endcase
    return w;
  endfunction

  task automatic send_word(input logic full, input logic [31:0] w,
                           input logic [3:0] want_len);
    int gap;
    gap = src_idle_on ? $urandom_range(0, 17) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid          <= 1'b1;
    in_ch.have_full_word <= full;
    in_ch.instr_word     <= w;
    do @(posedge clk_i); while (!in_ch.ready);
    len_q.push_back(want_len);
  endtask

  task automatic wait_all_lengths();
    in_ch.valid <= 1'b0;
    while (len_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_generation(input logic [1:0] gen);
    wait_all_lengths();
    repeat (4) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= gen;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    gen_shadow  = gen;
  endtask

  // Source side: directed table, then random phases over every generation.
  initial begin
    logic [1:0]  phase_gen [NUM_PHASES];
    logic        full;
    logic [31:0] w;
    phase_gen = '{gild_pkg::GEN_SECOND, gild_pkg::GEN_FIRST, gild_pkg::GEN_THIRD,
                  GEN_CODE3, gild_pkg::GEN_SECOND, gild_pkg::GEN_THIRD,
                  gild_pkg::GEN_FIRST, GEN_CODE3};
    rst_ni               = 1'b0;
    cfg_we_i             = 1'b0;
    cfg_wdata_i          = gild_pkg::GEN_FIRST;
    in_ch.valid          = 1'b0;
    in_ch.have_full_word = 1'b0;
    in_ch.instr_word     = '0;
    gen_shadow           = gild_pkg::GEN_FIRST;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // The first rows run on the reset value of the generation register.
    foreach (dir_rows[i]) begin
      if (dir_rows[i].gen != gen_shadow) write_generation(dir_rows[i].gen);
      send_word(dir_rows[i].full, dir_rows[i].word,
                dir_rows[i].fixed ? dir_rows[i].len
                  : predict_length(gen_shadow, dir_rows[i].full, dir_rows[i].word));
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_generation(phase_gen[p]);
      src_idle_on = (p % 4 != 1) && (p != 3);
      snk_idle_on = (p % 4 != 2);
      // Stall the sink for a long stretch while words keep coming, so the
      // pipeline fills and back-pressure reaches the input.
      if (p == 3) hold_req = 1'b1;
      for (int n = 0; n < PHASE_WORDS; n++) begin
        if (p == 5 && n == PHASE_WORDS / 2) wait_all_lengths();
        full = ($urandom_range(0, 9) != 0);
        w    = random_instr_word();
        send_word(full, w, predict_length(gen_shadow, full, w));
      end
    end

    wait_all_lengths();
    repeat (10) @(posedge clk_i);
    run_done = 1'b1;
    if (mismatches == 0) begin
      $display("gpu_instruction_length_decode: match");
    end else begin
      $display("gpu_instruction_length_decode: mismatch");
    end
    $finish;
  end

  // Sink side: a random stall before each word, or one long hold on request.
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        stall = snk_idle_on ? $urandom_range(0, 17) : 0;
        if (stall > 0) begin
          out_ch.ready <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!(out_ch.valid && out_ch.ready));
    end
  end

  always @(posedge clk_i) begin
    logic [3:0] want;
    if (rst_ni && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (len_q.size() == 0) begin
        $error("length_bytes: expected nothing, got %0d", out_ch.length_bytes);
        mismatches++;
      end else begin
        want = len_q.pop_front();
        if (out_ch.length_bytes !== want) begin
          $error("length_bytes: expected %0d, got %0d", want, out_ch.length_bytes);
          mismatches++;
        end
      end
    end
  end

  // Ends the run if no word moves on either side for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || run_done ||
        (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_count = 0;
    end else begin
      stall_count++;
      if (stall_count >= STALL_LIMIT) begin
        $display("gpu_instruction_length_decode: mismatch");
        $finish;
      end
    end
  end

endmodule

@@ files.f @@
rtl/gild_pkg.sv
rtl/gild_if.sv
rtl/gild_classify.sv
rtl/gpu_instruction_length_decode.sv
rtl/gild_checker.sv
sim/tb.sv
